>>> hw/rtl/nconv_pkg.sv
// shared types, type codes and helper functions for the numeric type converter
package nconv_pkg;

    // type codes
    localparam logic [3:0] TY_I8  = 4'd0;
    localparam logic [3:0] TY_I16 = 4'd1;
    localparam logic [3:0] TY_I32 = 4'd2;
    localparam logic [3:0] TY_I64 = 4'd3;
    localparam logic [3:0] TY_U8  = 4'd4;
    localparam logic [3:0] TY_U16 = 4'd5;
    localparam logic [3:0] TY_U32 = 4'd6;
    localparam logic [3:0] TY_U64 = 4'd7;
    localparam logic [3:0] TY_F32 = 4'd8;
    localparam logic [3:0] TY_F64 = 4'd9;

    // configuration register indexes
    localparam logic REG_SOURCE_TYPE = 1'b0;
    localparam logic REG_DEST_TYPE   = 1'b1;

    // per item control that travels with the data
    typedef struct packed {
        logic        last;
        logic [3:0]  dt;
        logic        direct;
        logic        dflag;
        logic        sign;
        logic [63:0] dbits;
    } ctl_t;

    // after unpacking
    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        mag;
        logic signed [12:0] expo;
    } s1_t;

    // after leading zero count
    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        mag;
        logic signed [12:0] expo;
        logic [6:0]         lz;
    } s2_t;

    // after normalisation
    typedef struct packed {
        ctl_t               ctl;
        logic [63:0]        man;
        logic signed [12:0] en;
    } s3_t;

    // after alignment to the destination
    typedef struct packed {
        ctl_t        ctl;
        logic [63:0] kept;
        logic        guard;
        logic        sticky;
        logic        ovf;
        logic [10:0] ebase;
    } s4_t;

    function automatic logic is_int(input logic [3:0] t);
        return t < TY_F32;
    endfunction

    function automatic logic is_signed_int(input logic [3:0] t);
        return t < TY_U8;
    endfunction

    // mask of the bits a type occupies
    function automatic logic [63:0] type_mask(input logic [3:0] t);
        logic [63:0] m;
        m = 64'd0;
        case (t)
            TY_I8, TY_U8:   m = 64'h0000_0000_0000_00FF;
            TY_I16, TY_U16: m = 64'h0000_0000_0000_FFFF;
            TY_I32, TY_U32, TY_F32: m = 64'h0000_0000_FFFF_FFFF;
            TY_I64, TY_U64, TY_F64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:        m = 64'd0;
        endcase
        return m;
    endfunction

    // top bit of an integer type
    function automatic logic [63:0] type_half(input logic [3:0] t);
        logic [63:0] h;
        h = 64'd0;
        case (t[1:0])
            2'd0:    h = 64'h0000_0000_0000_0080;
            2'd1:    h = 64'h0000_0000_0000_8000;
            2'd2:    h = 64'h0000_0000_8000_0000;
            default: h = 64'h8000_0000_0000_0000;
        endcase
        return h;
    endfunction

    // saturation value of an integer type on the side given by neg
    function automatic logic [63:0] int_sat(input logic [3:0] t, input logic neg);
        logic [63:0] r;
        if (is_signed_int(t))
            r = neg ? type_half(t) : (type_half(t) - 64'd1);
        else
            r = neg ? 64'd0 : type_mask(t);
        return r;
    endfunction

endpackage

>>> hw/rtl/nconv_unpack.sv
// first stage: masks the source, resolves direct cases and unpacks to sign, magnitude, exponent
module nconv_unpack import nconv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] in_bits,
    input  logic        in_last,
    input  logic [3:0]  src_type,
    input  logic [3:0]  dst_type,
    output logic        s1_valid,
    output s1_t         s1
);

    logic        s1_valid_reg;
    s1_t         s1_reg;
    s1_t         s1_next;

    logic [63:0] sm;
    logic [63:0] dm;
    logic [63:0] sb;
    logic [63:0] v;
    logic        neg;
    logic        fsign;
    logic        fnan;
    logic        finf;
    logic        fzero;
    logic [10:0] fexp;
    logic [63:0] fmag;
    logic [63:0] nan_bits;
    logic        known;

    // source fields
    always_comb
    begin
        sm    = type_mask(src_type);
        dm    = type_mask(dst_type);
        sb    = in_bits & sm;
        neg   = is_signed_int(src_type) && ((sb & type_half(src_type)) != 64'd0);
        v     = neg ? (sb | ~sm) : sb;
        known = (src_type <= TY_F64) && (dst_type <= TY_F64);
        if (src_type == TY_F32)
        begin
            fsign    = sb[31];
            fnan     = (sb[30:23] == 8'hFF) && (sb[22:0] != 23'd0);
            finf     = (sb[30:23] == 8'hFF) && (sb[22:0] == 23'd0);
            fzero    = (sb[30:0] == 31'd0);
            fexp     = {3'd0, sb[30:23]};
            fmag     = {40'd0, (sb[30:23] != 8'd0), sb[22:0]};
            nan_bits = {sb[31], 11'h7FF, 1'b1, sb[21:0], 29'd0};
        end
        else
        begin
            fsign    = sb[63];
            fnan     = (sb[62:52] == 11'h7FF) && (sb[51:0] != 52'd0);
            finf     = (sb[62:52] == 11'h7FF) && (sb[51:0] == 52'd0);
            fzero    = (sb[62:0] == 63'd0);
            fexp     = sb[62:52];
            fmag     = {11'd0, (sb[62:52] != 11'd0), sb[51:0]};
            nan_bits = {32'd0, sb[63], 8'hFF, 1'b1, sb[50:29]};
        end
    end

    // decision between direct result and the arithmetic path
    always_comb
    begin
        s1_next.ctl.last   = in_last;
        s1_next.ctl.dt     = dst_type;
        s1_next.ctl.direct = 1'b1;
        s1_next.ctl.dflag  = 1'b0;
        s1_next.ctl.sign   = 1'b0;
        s1_next.ctl.dbits  = 64'd0;
        s1_next.mag        = 64'd0;
        s1_next.expo       = 13'sd0;
        if (!known)
        begin
            s1_next.ctl.dbits = 64'd0;
        end
        else if (src_type == dst_type)
        begin
            s1_next.ctl.dbits = sb;
        end
        else if (is_int(src_type))
        begin
            if (is_int(dst_type))
                s1_next.ctl.dbits = v & dm;
            else if (sb == 64'd0)
                s1_next.ctl.dbits = 64'd0;
            else
            begin
                s1_next.ctl.direct = 1'b0;
                s1_next.ctl.sign   = neg;
                s1_next.mag        = neg ? (~v + 64'd1) : v;
                s1_next.expo       = 13'sd0;
            end
        end
        else
        begin
            s1_next.ctl.sign = fsign;
            if (is_int(dst_type))
            begin
                if (fnan)
                begin
                    s1_next.ctl.dbits = 64'd0;
                    s1_next.ctl.dflag = 1'b1;
                end
                else if (finf)
                begin
                    s1_next.ctl.dbits = int_sat(dst_type, fsign);
                    s1_next.ctl.dflag = 1'b1;
                end
                else if (fzero)
                    s1_next.ctl.dbits = 64'd0;
                else
                    s1_next.ctl.direct = 1'b0;
            end
            else
            begin
                // float to the other float type
                if (fnan)
                    s1_next.ctl.dbits = nan_bits;
                else if (finf)
                    s1_next.ctl.dbits = (dst_type == TY_F64) ?
                        {fsign, 11'h7FF, 52'd0} : {32'd0, fsign, 8'hFF, 23'd0};
                else if (fzero)
                    s1_next.ctl.dbits = (dst_type == TY_F64) ?
                        {fsign, 63'd0} : {32'd0, fsign, 31'd0};
                else
                    s1_next.ctl.direct = 1'b0;
            end
            s1_next.mag = fmag;
            // exponent of the lsb of the magnitude
            if (src_type == TY_F32)
                s1_next.expo = $signed({2'b00, (fexp == 11'd0) ? 11'd1 : fexp}) - 13'sd150;
            else
                s1_next.expo = $signed({2'b00, (fexp == 11'd0) ? 11'd1 : fexp}) - 13'sd1075;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

>>> hw/rtl/nconv_norm.sv
// second and third stages: leading zero count, then left shift to put the msb at bit 63
module nconv_norm import nconv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s1_valid,
    input  s1_t  s1,
    output logic s3_valid,
    output s3_t  s3
);

    logic       s2_valid_reg;
    s2_t        s2_reg;
    s2_t        s2_next;
    logic       s3_valid_reg;
    s3_t        s3_reg;
    s3_t        s3_next;
    logic [6:0] lz;
    logic       found;

    // leading zero count
    always_comb
    begin
        lz    = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found && s1.mag[i])
            begin
                found = 1'b1;
                lz    = 7'(63 - i);
            end
        end
        s2_next.ctl  = s1.ctl;
        s2_next.mag  = s1.mag;
        s2_next.expo = s1.expo;
        s2_next.lz   = lz;
    end

    // normalising shift and exponent of the msb
    always_comb
    begin
        s3_next.ctl = s2_reg.ctl;
        s3_next.man = s2_reg.mag << s2_reg.lz;
        s3_next.en  = s2_reg.expo + 13'sd63 - $signed({6'd0, s2_reg.lz});
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    assign s3_valid = s3_valid_reg;
    assign s3       = s3_reg;

endmodule

>>> hw/rtl/nconv_align.sv
// fourth stage: right shift to the destination precision with guard and sticky bits
module nconv_align import nconv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s3_valid,
    input  s3_t  s3,
    output logic s4_valid,
    output s4_t  s4
);

    logic               s4_valid_reg;
    s4_t                s4_reg;
    s4_t                s4_next;
    logic signed [12:0] emin;
    logic signed [12:0] emax;
    logic signed [12:0] bias;
    logic signed [12:0] shp;
    logic signed [12:0] sh_wide;
    logic [6:0]         sh;
    logic [127:0]       ext;
    logic               sub;
    logic signed [12:0] eb;

    always_comb
    begin
        // destination format limits
        if (s3.ctl.dt == TY_F64)
        begin
            emin = -13'sd1022;
            emax = 13'sd1023;
            bias = 13'sd1023;
            shp  = 13'sd11;
        end
        else
        begin
            emin = -13'sd126;
            emax = 13'sd127;
            bias = 13'sd127;
            shp  = 13'sd40;
        end
        sub = s3.en < emin;
        eb  = s3.en + bias - 13'sd1;
        if (is_int(s3.ctl.dt))
        begin
            sh_wide      = (s3.en < 13'sd0) ? 13'sd127 : (13'sd63 - s3.en);
            s4_next.ovf  = s3.en > 13'sd63;
            s4_next.ebase = 11'd0;
        end
        else
        begin
            sh_wide      = sub ? (shp + emin - s3.en) : shp;
            s4_next.ovf  = s3.en > emax;
            s4_next.ebase = sub ? 11'd0 : eb[10:0];
        end
        sh = (sh_wide > 13'sd127) ? 7'd127 : sh_wide[6:0];
        // shift with the dropped bits kept below for rounding
        ext            = {s3.man, 64'd0} >> sh;
        s4_next.ctl    = s3.ctl;
        s4_next.kept   = ext[127:64];
        s4_next.guard  = ext[63];
        s4_next.sticky = |ext[62:0];
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
    end

    assign s4_valid = s4_valid_reg;
    assign s4       = s4_reg;

endmodule

>>> hw/rtl/nconv_round.sv
// fifth stage: rounding and packing for floats, range check for integers, output register
module nconv_round import nconv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s4_valid,
    input  s4_t         s4,
    output logic        out_valid,
    output logic [63:0] out_bits,
    output logic        out_of_range,
    output logic        out_last
);

    logic        out_valid_reg;
    logic [63:0] bits_reg;
    logic [63:0] bits_next;
    logic        flag_reg;
    logic        flag_next;
    logic        last_reg;
    logic        inc;
    logic [64:0] sum;
    logic [63:0] pk64;
    logic [30:0] pk32;
    logic [63:0] mask;
    logic [63:0] half;
    logic        sat;

    always_comb
    begin
        // round to nearest even
        inc  = s4.guard & (s4.sticky | s4.kept[0]);
        sum  = {1'b0, s4.kept} + {64'd0, inc};
        pk64 = {1'b0, s4.ebase, 52'd0} + sum[63:0];
        pk32 = {s4.ebase[7:0], 23'd0} + sum[30:0];
        mask = type_mask(s4.ctl.dt);
        half = type_half(s4.ctl.dt);
        // integer range check on the truncated magnitude
        if (s4.ovf)
            sat = 1'b1;
        else if (is_signed_int(s4.ctl.dt))
            sat = s4.ctl.sign ? (s4.kept > half) : (s4.kept >= half);
        else
            sat = s4.ctl.sign ? (s4.kept != 64'd0) : ((s4.kept & ~mask) != 64'd0);
        flag_next = 1'b0;
        if (s4.ctl.direct)
        begin
            bits_next = s4.ctl.dbits;
            flag_next = s4.ctl.dflag;
        end
        else if (s4.ctl.dt == TY_F64)
            bits_next = s4.ovf ? {s4.ctl.sign, 11'h7FF, 52'd0} : {s4.ctl.sign, pk64[62:0]};
        else if (s4.ctl.dt == TY_F32)
            bits_next = s4.ovf ? {32'd0, s4.ctl.sign, 8'hFF, 23'd0}
                               : {32'd0, s4.ctl.sign, pk32};
        else if (sat)
        begin
            bits_next = int_sat(s4.ctl.dt, s4.ctl.sign);
            flag_next = 1'b1;
        end
        else
            bits_next = (s4.ctl.sign ? (~s4.kept + 64'd1) : s4.kept) & mask;
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= s4_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        flag_reg <= flag_next;
        last_reg <= s4.ctl.last;
    end

    assign out_valid    = out_valid_reg;
    assign out_bits     = bits_reg;
    assign out_of_range = flag_reg;
    assign out_last     = last_reg;

endmodule

>>> hw/rtl/numeric_type_converter_core.sv
// top level of the numeric type converter: configuration registers and the five stage pipeline
//
//  channel   signals                                   handshake
//  input     start, busy, in_bits, in_last             taken when start and not busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data taken when cfg_valid and cfg_ready
//  result    out_valid, out_bits, out_of_range,        one cycle strobe, always taken
//            out_last
//
//  one item per cycle; each result is produced by the five register stages: unpack,
//  leading zero count, normalising shift, alignment, rounding and packing
//  busy is always low and cfg_ready always high: nothing in the pipeline can stall
//  reset clears the stage valid bits and sets both type registers to int8
module numeric_type_converter_core import nconv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] in_bits,
    input  logic        in_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    output logic [63:0] out_bits,
    output logic        out_of_range,
    output logic        out_last
);

    logic [3:0] src_type_reg;
    logic [3:0] dst_type_reg;
    logic       in_valid;
    logic       s1_valid;
    s1_t        s1;
    logic       s3_valid;
    s3_t        s3;
    logic       s4_valid;
    s4_t        s4;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    // type registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_type_reg <= TY_I8;
            dst_type_reg <= TY_I8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SOURCE_TYPE)
                src_type_reg <= cfg_data;
            else
                dst_type_reg <= cfg_data;
        end
    end

    nconv_unpack u_unpack (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_bits  (in_bits),
        .in_last  (in_last),
        .src_type (src_type_reg),
        .dst_type (dst_type_reg),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    nconv_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    nconv_align u_align (
        .clk      (clk),
        .rst_n    (rst_n),
        .s3_valid (s3_valid),
        .s3       (s3),
        .s4_valid (s4_valid),
        .s4       (s4)
    );

    nconv_round u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .s4_valid     (s4_valid),
        .s4           (s4),
        .out_valid    (out_valid),
        .out_bits     (out_bits),
        .out_of_range (out_of_range),
        .out_last     (out_last)
    );

    // a taken item reaches the first stage on the next edge
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> s1_valid)
        else $error("item lost at pipeline entry");

    // every item in the alignment stage leads to a result strobe
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid |=> out_valid)
        else $error("item lost at pipeline exit");

    // no float result with an arithmetic integer saturation flag
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid && !s4.ctl.direct && !is_int(s4.ctl.dt)) |=> !out_of_range)
        else $error("range flag on a float result");

    // a single precision result leaves the upper half clear
    a_f32: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid && (s4.ctl.dt == TY_F32)) |=> (out_bits[63:32] == 32'd0))
        else $error("upper bits set on single precision result");

endmodule

>>> tb/tb_numeric_type_converter_core.sv
// self-checking testbench for the numeric type converter core
`timescale 1ns / 1ps

module tb_numeric_type_converter_core;
    import nconv_pkg::*;

    typedef struct {
        logic [63:0] bits;
        logic        oor;
        logic        last;
    } conv_result_t;

    // expected results of the converter, computed from the accepted items
    class conv_scoreboard;
        logic [3:0]   src_ty;
        logic [3:0]   dst_ty;
        conv_result_t pending_q[$];
        int           errors;

        function new();
            src_ty = TY_I8;
            dst_ty = TY_I8;
            errors = 0;
        endfunction

        function logic [63:0] ty_mask(logic [3:0] t);
            int w;
            w = (t == TY_F32) ? 32 : (t == TY_F64) ? 64 : (8 << t[1:0]);
            return (w == 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
        endfunction

        function int msb_of(logic [63:0] v);
            int k;
            k = 63;
            while (k > 0 && !v[k]) k--;
            return k;
        endfunction

        // sign * mag * 2^e rounded to nearest even into binary32 or binary64
        function logic [63:0] round_to_float(logic sign, logic [63:0] mag, int e, logic dbl);
            int p, bias, emax, k, tgt, sh, biased;
            logic [127:0] x;
            logic [63:0] kept, frac;
            logic g, st;
            p = dbl ? 53 : 24;
            bias = dbl ? 1023 : 127;
            emax = dbl ? 2047 : 255;
            if (mag == 64'd0)
                return dbl ? {sign, 63'd0} : {32'd0, sign, 31'd0};
            k = msb_of(mag);
            tgt = k + e - (p - 1);
            if (tgt < 1 - bias - (p - 1)) tgt = 1 - bias - (p - 1);
            sh = tgt - e;
            if (sh <= 0) begin
                kept = mag << (-sh);
                g = 1'b0;
                st = 1'b0;
            end else if (sh <= 128) begin
                x = {mag, 64'd0} >> sh;
                kept = x[127:64];
                g = x[63];
                st = |x[62:0];
            end else begin
                kept = 64'd0;
                g = 1'b0;
                st = 1'b1;
            end
            if (g && (st || kept[0])) kept = kept + 64'd1;
            if (kept[p]) begin
                kept = kept >> 1;
                tgt++;
            end
            // below the hidden bit means subnormal
            if (kept < (64'd1 << (p - 1))) biased = 0;
            else biased = tgt + (p - 1) + bias;
            if (biased >= emax) begin
                biased = emax;
                kept = 64'd0;
            end
            frac = kept & ((64'd1 << (p - 1)) - 64'd1);
            if (dbl) return {sign, biased[10:0], frac[51:0]};
            return {32'd0, sign, biased[7:0], frac[22:0]};
        endfunction

        function conv_result_t convert(logic [63:0] in_bits, logic in_last);
            conv_result_t r;
            logic [63:0] sb, v, mag, ip, half, m;
            logic neg, nan, inf, big, sgn;
            int e, w, k;
            r.bits = 64'd0;
            r.oor = 1'b0;
            r.last = in_last;
            if (src_ty > TY_F64 || dst_ty > TY_F64) return r;
            sb = in_bits & ty_mask(src_ty);
            if (src_ty == dst_ty) begin
                r.bits = sb;
            end else if (src_ty < TY_F32) begin
                // integer source: sign extend, then wrap or round
                w = 8 << src_ty[1:0];
                neg = (src_ty < TY_U8) && sb[w-1];
                v = neg ? (sb | ~ty_mask(src_ty)) : sb;
                if (dst_ty < TY_F32) r.bits = v;
                else r.bits = round_to_float(neg, neg ? -v : v, 0, dst_ty == TY_F64);
            end else begin
                // float source decoded to sign, magnitude and exponent
                if (src_ty == TY_F32) begin
                    sgn = sb[31];
                    nan = (sb[30:23] == 8'hFF) && (sb[22:0] != 0);
                    inf = (sb[30:23] == 8'hFF) && (sb[22:0] == 0);
                    mag = (sb[30:23] == 0) ? {41'd0, sb[22:0]} : {40'd0, 1'b1, sb[22:0]};
                    e = (sb[30:23] == 0) ? -149 : int'(sb[30:23]) - 150;
                end else begin
                    sgn = sb[63];
                    nan = (sb[62:52] == 11'h7FF) && (sb[51:0] != 0);
                    inf = (sb[62:52] == 11'h7FF) && (sb[51:0] == 0);
                    mag = (sb[62:52] == 0) ? {12'd0, sb[51:0]} : {11'd0, 1'b1, sb[51:0]};
                    e = (sb[62:52] == 0) ? -1074 : int'(sb[62:52]) - 1075;
                end
                if (dst_ty < TY_F32) begin
                    // truncate toward zero, saturate out of range
                    w = 8 << dst_ty[1:0];
                    m = ty_mask(dst_ty);
                    big = inf;
                    ip = 64'd0;
                    if (!inf && mag != 0) begin
                        k = msb_of(mag);
                        if (k + e >= 64) big = 1'b1;
                        else if (e >= 0) ip = mag << e;
                        else ip = (-e >= 64) ? 64'd0 : (mag >> (-e));
                    end
                    half = 64'd1 << (w - 1);
                    if (nan) begin
                        r.oor = 1'b1;
                    end else if (dst_ty < TY_U8) begin
                        if (!sgn && (big || ip >= half)) begin
                            r.bits = half - 64'd1;
                            r.oor = 1'b1;
                        end else if (sgn && (big || ip > half)) begin
                            r.bits = half;
                            r.oor = 1'b1;
                        end else begin
                            r.bits = sgn ? -ip : ip;
                        end
                    end else begin
                        if (!sgn && (big || (w < 64 && ip >= (64'd1 << w)))) begin
                            r.bits = m;
                            r.oor = 1'b1;
                        end else if (sgn && (big || ip != 0)) begin
                            r.oor = 1'b1;
                        end else if (!sgn) begin
                            r.bits = ip;
                        end
                    end
                end else if (nan) begin
                    // quiet the nan, keep the top of the payload
                    if (dst_ty == TY_F64)
                        r.bits = {sgn, 11'h7FF, 1'b1, sb[21:0], 29'd0};
                    else
                        r.bits = {32'd0, sgn, 8'hFF, 1'b1, sb[50:29]};
                end else if (inf) begin
                    r.bits = (dst_ty == TY_F64) ? {sgn, 11'h7FF, 52'd0}
                                                : {32'd0, sgn, 8'hFF, 23'd0};
                end else begin
                    r.bits = round_to_float(sgn, mag, e, dst_ty == TY_F64);
                end
            end
            r.bits = r.bits & ty_mask(dst_ty);
            return r;
        endfunction

        function void note_item(logic [63:0] in_bits, logic in_last);
            pending_q.push_back(convert(in_bits, in_last));
        endfunction

        function void check_result(logic [63:0] bits, logic oor, logic last);
            conv_result_t x;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result bits=%h oor=%b last=%b", $time, bits, oor, last);
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (bits !== x.bits) begin
                $display("%0t: out_bits expected %h actual %h", $time, x.bits, bits);
                errors++;
            end
            if (oor !== x.oor) begin
                $display("%0t: out_of_range expected %b actual %b", $time, x.oor, oor);
                errors++;
            end
            if (last !== x.last) begin
                $display("%0t: out_last expected %b actual %b", $time, x.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] in_bits;
    logic        in_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        out_valid;
    logic [63:0] out_bits;
    logic        out_of_range;
    logic        out_last;

    conv_scoreboard conv_sb;
    int             cycles;
    int             item_count;
    logic           no_gaps;

    numeric_type_converter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_bits      (in_bits),
        .in_last      (in_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_bits     (out_bits),
        .out_of_range (out_of_range),
        .out_last     (out_last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
            conv_sb.check_result(out_bits, out_of_range, out_last);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[numeric_type_converter_core] ERROR");
            $finish;
        end
    end

    // random idle length, mostly short
    function int gap_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (no_gaps || sel < 6) return 0;
        if (sel < 9) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(logic [63:0] bits, logic last);
        int g;
        start <= 1'b1;
        in_bits <= bits;
        in_last <= last;
        do @(posedge clk); while (busy);
        conv_sb.note_item(bits, last);
        item_count++;
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (conv_sb.pending_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_SOURCE_TYPE) conv_sb.src_ty = data;
        else conv_sb.dst_ty = data;
    endtask

    task automatic set_types(logic [3:0] s, logic [3:0] d);
        wait_drained();
        write_reg(REG_SOURCE_TYPE, s);
        write_reg(REG_DEST_TYPE, d);
        cfg_valid <= 1'b0;
    endtask

    // random element shaped for the current source type
    function logic [63:0] rand_element(logic [3:0] t);
        logic [63:0] r;
        logic [10:0] ex;
        logic [51:0] fr;
        int sel;
        r = {$urandom, $urandom};
        sel = $urandom_range(0, 7);
        if (t == TY_F32 || t == TY_F64)
        begin
            case (sel)
                0: ex = 11'd0;
                1: ex = 11'h7FF;
                2, 3: ex = 11'($urandom_range(0, 66));
                4: ex = 11'(-$urandom_range(1, 3));
                default: ex = 11'($urandom);
            endcase
            fr = 52'({$urandom, $urandom});
            case ($urandom_range(0, 5))
                0: fr = 52'd0;
                1: fr = {52{1'b1}};
                2: fr = 52'd1;
                default: ;
            endcase
            if (t == TY_F32)
            begin
                if (sel >= 2 && sel <= 4) ex = ex + 11'd127;
                r[31:0] = {r[31], ex[7:0], fr[22:0]};
                if (sel == 1) r[30:23] = 8'hFF;
            end
            else
            begin
                if (sel >= 2 && sel <= 4) ex = ex + 11'd1023;
                r = {r[63], ex, fr};
            end
        end
        else
        begin
            case (sel)
                0: r = 64'd0;
                1: r = {64{1'b1}};
                2: r = 64'd1 << ((8 << t[1:0]) - 1);
                3: r = (64'd1 << ((8 << t[1:0]) - 1)) - 64'd1;
                4: r = 64'($urandom_range(0, 300));
                default: ;
            endcase
            if (sel < 4 && (8 << t[1:0]) < 64)
                r = r | ({$urandom, $urandom} << (8 << t[1:0]));
        end
        return r;
    endfunction

    logic [63:0] f64_edges [0:11];
    logic [63:0] f32_edges [0:4];

    initial
    begin
        logic [3:0] s, d;
        int n;
        conv_sb = new();
        cycles = 0;
        item_count = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        in_bits = 64'd0;
        in_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_TYPE;
        cfg_data = TY_I8;
        f64_edges = '{64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000,
                      64'h7FF0_0000_0000_0000, 64'h43E0_0000_0000_0000,
                      64'hC3E0_0000_0000_0000, 64'hC3E0_0000_0000_0001,
                      64'h43DF_FFFF_FFFF_FFFF, 64'hBFEF_FFFF_FFFF_FFFF,
                      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                      64'hBFF0_0000_0000_0000, 64'h3FE0_0000_0000_0000};
        f32_edges = '{64'hFFFF_FFFF_7FC0_0001, 64'h0000_0000_7F7F_FFFF,
                      64'h0000_0000_0000_0001, 64'h0000_0000_4F80_0000,
                      64'h0000_0000_CF00_0000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset types int8 to int8 with an all-ones element
        send_item({64{1'b1}}, 1'b1);

        // directed edges: float limits into the widest signed integer and into uint32, then int64 into float32
        set_types(TY_F64, TY_I64);
        for (int i = 0; i < 12; i++) send_item(f64_edges[i], i == 11);
        set_types(TY_F32, TY_U32);
        for (int i = 0; i < 5; i++) send_item(f32_edges[i], i == 4);
        set_types(TY_I64, TY_F32);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'h0000_0000_0100_0001, 1'b1);

        // sweep every type pair with random elements, stalling before each change
        for (int si = 0; si <= 9; si++)
        begin
            for (int di = 0; di <= 9; di++)
            begin
                s = 4'(si);
                d = 4'(di);
                set_types(s, d);
                no_gaps = ($urandom_range(0, 3) == 0);
                n = $urandom_range(4, 14);
                for (int j = 0; j < n; j++)
                    send_item(rand_element(s), (j == n - 1) || ($urandom_range(0, 7) == 0));
            end
        end

        // unknown type codes in the source, in both and in the destination register, plus one known pair
        for (int i = 0; i < 4; i++)
        begin
            s = (i < 2) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
            d = (i == 1 || i == 3) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
            if (i == 0) s = 4'd15;
            set_types(s, d);
            for (int j = 0; j < 6; j++)
                send_item({$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (conv_sb.errors == 0 && conv_sb.pending_q.size() == 0)
            $display("[numeric_type_converter_core] OK");
        else
            $display("[numeric_type_converter_core] ERROR");
        $finish;
    end

endmodule

>>> numeric_type_converter_core.f
hw/rtl/nconv_pkg.sv
hw/rtl/nconv_unpack.sv
hw/rtl/nconv_norm.sv
hw/rtl/nconv_align.sv
hw/rtl/nconv_round.sv
hw/rtl/numeric_type_converter_core.sv
tb/tb_numeric_type_converter_core.sv
